// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold on the same edge as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold on the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/bdmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdmc_pkg
// Shared widths, codes and types of the button debounce and click counter.
// ----------------------------------------------------------------------------
package bdmc_pkg;

   localparam int TIMER_BITS = 16;
   localparam int CFG_BITS   = 16;
   localparam int COUNT_BITS = 8;

   typedef logic [TIMER_BITS-1:0] timer_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // Request codes.
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_STOP  = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;

   // Register indexes.
   localparam logic [1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [1:0] CSR_WINDOW   = 2'd1;
   localparam logic [1:0] CSR_SKIP     = 2'd2;

   typedef struct packed {
      logic [CFG_BITS-1:0] debounce_ticks;
      logic [CFG_BITS-1:0] multi_click_ticks;
      logic                skip_debounce;
   } cfg_type;

   typedef struct packed {
      logic      emit;
      count_type click_count;
   } result_type;

endpackage

// ===== hw/rtl/button_debounce_multi_click.sv =====
// ----------------------------------------------------------------------------
// button_debounce_multi_click
// Debounces an active-low button sampled once per tick and reports the
// number of clicks in each multi-click sequence.
// ----------------------------------------------------------------------------
// One item is accepted in every cycle unless the input side stalls. An
// accepted item lands in the input register and is processed from there by
// the update of the mode, timer and click count, so a tick that finishes a
// sequence passes through the input register, and its click count is then
// written into the result register.
// The input side stalls only when the item in the input register produces a
// click count while the result register still holds one that has not been
// taken. Registers should be written while no item is in flight.
module button_debounce_multi_click
   import bdmc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic                req_pin_level,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_click_count,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [CFG_BITS-1:0] csr_write_data
);

   cfg_type    cfg;
   result_type result;

   logic       item_valid_ff, item_valid_in;
   logic [1:0] item_type_ff;
   logic       item_pin_ff;
   logic       out_valid_ff, out_valid_in;
   count_type  out_count_ff;
   logic       out_free;
   logic       step;
   logic       take;

   bdmc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bdmc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item_type (item_type_ff),
      .item_pin  (item_pin_ff),
      .cfg       (cfg),
      .result    (result)
   );

   always_comb begin
      out_free      = ~out_valid_ff | ~rsp_stall;
      step          = item_valid_ff & (~result.emit | out_free);
      req_stall     = item_valid_ff & ~step;
      take          = req_valid & ~req_stall;
      item_valid_in = take | (item_valid_ff & ~step);
      out_valid_in  = (step & result.emit) | (out_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_type_ff <= req_type;
         item_pin_ff  <= req_pin_level;
      end
      if (step && result.emit) begin
         out_count_ff <= result.click_count;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_click_count = out_count_ff;

endmodule

// ===== hw/rtl/bdmc_csr.sv =====
// ----------------------------------------------------------------------------
// bdmc_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bdmc_csr
   import bdmc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [CFG_BITS-1:0] csr_write_data,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ticks    = csr_write_data;
            CSR_WINDOW:   cfg_in.multi_click_ticks = csr_write_data;
            CSR_SKIP:     cfg_in.skip_debounce     = csr_write_data[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks    <= CFG_BITS'(20);
         cfg_ff.multi_click_ticks <= CFG_BITS'(300);
         cfg_ff.skip_debounce     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/bdmc_core.sv =====
// ----------------------------------------------------------------------------
// bdmc_core
// Mode, timer, click count and edge detection; one item per step.
// ----------------------------------------------------------------------------
module bdmc_core
   import bdmc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [1:0] item_type,
   input  logic       item_pin,
   input  cfg_type    cfg,
   output result_type result
);

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_DEBOUNCE = 2'd1,
      MODE_WINDOW   = 2'd2,
      MODE_SUSPEND  = 2'd3
   } mode_type;

   mode_type  mode_ff, mode_in;
   count_type clicks_ff, clicks_in;
   timer_type ticks_ff, ticks_in;
   logic      prev_ff, prev_in;

   timer_type  debounce_load;
   timer_type  window_load;
   logic       edge_seen;
   logic       expires;
   timer_type  ticks_dec;
   count_type  clicks_inc;
   count_type  pressed;
   logic       press_done;
   result_type result_c;

   always_comb begin
      debounce_load = timer_type'(cfg.debounce_ticks);
      window_load   = timer_type'(cfg.multi_click_ticks);
      edge_seen     = prev_ff & ~item_pin;
      expires       = (ticks_ff <= timer_type'(1));
      ticks_dec     = expires ? '0 : ticks_ff - timer_type'(1);
      clicks_inc    = clicks_ff + count_type'(1);

      mode_in    = mode_ff;
      clicks_in  = clicks_ff;
      ticks_in   = ticks_ff;
      prev_in    = prev_ff;
      pressed    = clicks_ff;
      press_done = 1'b0;
      result_c   = '0;

      unique case (item_type)
         REQ_STOP: begin
            mode_in  = MODE_SUSPEND;
            ticks_in = '0;
         end
         REQ_START: begin
            mode_in   = MODE_IDLE;
            clicks_in = '0;
            ticks_in  = '0;
         end
         REQ_TICK: begin
            prev_in = item_pin;
            if ((mode_ff == MODE_IDLE || mode_ff == MODE_WINDOW) && edge_seen) begin
               if (cfg.skip_debounce) begin
                  pressed    = clicks_inc;
                  press_done = 1'b1;
               end else begin
                  mode_in  = MODE_DEBOUNCE;
                  ticks_in = debounce_load;
               end
            end else if (mode_ff == MODE_DEBOUNCE) begin
               ticks_in = ticks_dec;
               if (expires) begin
                  // The press only counts if the pin is still held low.
                  pressed    = item_pin ? clicks_ff : clicks_inc;
                  press_done = 1'b1;
               end
            end else if (mode_ff == MODE_WINDOW) begin
               ticks_in = ticks_dec;
               if (expires) begin
                  result_c  = '{emit: 1'b1, click_count: clicks_ff};
                  mode_in   = MODE_IDLE;
                  clicks_in = '0;
               end
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase

      // A finished press either opens the click window or reports at once.
      if (press_done) begin
         if (cfg.multi_click_ticks == '0) begin
            result_c  = '{emit: 1'b1, click_count: pressed};
            mode_in   = MODE_IDLE;
            clicks_in = '0;
            ticks_in  = '0;
         end else begin
            mode_in   = MODE_WINDOW;
            clicks_in = pressed;
            ticks_in  = window_load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         clicks_ff <= '0;
         ticks_ff  <= '0;
         prev_ff   <= 1'b1;
      end else if (step) begin
         mode_ff   <= mode_in;
         clicks_ff <= clicks_in;
         ticks_ff  <= ticks_in;
         prev_ff   <= prev_in;
      end
   end

   assign result = result_c;

endmodule

// ===== hw/rtl/bdmc_checker.sv =====
// ----------------------------------------------------------------------------
// bdmc_checker
// Port-level checks on the button debounce and click counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdmc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_click_count
);

   logic rsp_held;

   assign rsp_held = rsp_valid && rsp_stall;

   // Reset empties the result register.
   `ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // The input side only backs up behind a held result.
   `ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_held, "stall without a held result")

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid, "held result dropped")

   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_held, $stable(rsp_click_count), "held result changed")

endmodule

bind button_debounce_multi_click bdmc_checker u_bdmc_checker (.*);
